// File: hw/rtl/tccs_pkg.sv
// Shared types and constants for the text console cursor and scroll engine.
package tccs_pkg;

    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int COLOR_W     = 4;
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 11;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, SPACE_CODE};

    localparam logic [COLOR_W-1:0] RESET_FOREGROUND = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BACKGROUND = 4'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

endpackage

// File: hw/rtl/tccs_if.sv
// Valid/ready channel interfaces for console commands and results.
interface tccs_in_if;
    logic                          valid;
    logic                          ready;
    logic [tccs_pkg::OP_W-1:0]     operation;
    logic [tccs_pkg::CHAR_W-1:0]   char_code;
    logic [tccs_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, output operation, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input operation, input char_code, input cell_index,
                  output ready);
endinterface

interface tccs_out_if;
    logic                            valid;
    logic                            ready;
    logic [tccs_pkg::CHAR_W-1:0]     cell_code;
    logic [tccs_pkg::ATTR_W-1:0]     cell_attribute;
    logic [tccs_pkg::ROW_OUT_W-1:0]  cursor_row_out;
    logic [tccs_pkg::COL_OUT_W-1:0]  cursor_column_out;
    logic                            scrolled;

    modport source (output valid, output cell_code, output cell_attribute,
                    output cursor_row_out, output cursor_column_out, output scrolled,
                    input ready);
    modport sink (input valid, input cell_code, input cell_attribute,
                  input cursor_row_out, input cursor_column_out, input scrolled,
                  output ready);
endinterface

// File: hw/rtl/tccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/tccs_ctrl.sv
// Sequencer: cursor state, row copy and blank fill sweeps, result register.
module tccs_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tccs_pkg::ATTR_W-1:0]         attr,
    tccs_in_if.sink                             in_ch,
    tccs_out_if.source                          out_ch,
    output logic                                mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]     mem_waddr,
    output logic [tccs_pkg::CELL_W-1:0]         mem_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]     mem_raddr,
    input  logic [tccs_pkg::CELL_W-1:0]         mem_rdata
);
    import tccs_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
    localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [AW-1:0]       row_base_reg, row_base_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                copy_pend_reg, copy_pend_next;
    logic [AW-1:0]       copy_addr_reg, copy_addr_next;
    logic [CELL_W-1:0]   blank_reg, blank_next;
    logic [CHAR_W-1:0]   rd_code_reg, rd_code_next;
    logic [ATTR_W-1:0]   rd_attr_reg, rd_attr_next;
    logic                scrolled_reg, scrolled_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_code_reg, out_code_next;
    logic [ATTR_W-1:0]   out_attr_reg, out_attr_next;
    logic [ROW_OUT_W-1:0] out_row_reg, out_row_next;
    logic [COL_OUT_W-1:0] out_col_reg, out_col_next;
    logic                out_scrolled_reg, out_scrolled_next;

    logic accept;
    logic is_newline;
    logic fill_go;
    logic char_write;
    logic read_in_range;
    logic emit_free;

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign accept        = in_ch.valid && in_ch.ready;
    assign is_newline    = (in_ch.char_code == NEWLINE_CODE);
    assign fill_go       = ((state_reg == S_FILL) || (state_reg == S_INIT)) && !copy_pend_reg;
    assign char_write    = accept && (in_ch.operation == OP_WRITE) && !is_newline;
    assign read_in_range = (32'(in_ch.cell_index) < CELLS);
    assign emit_free     = !out_valid_reg || out_ch.ready;

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.cell_code         = out_code_reg;
    assign out_ch.cell_attribute    = out_attr_reg;
    assign out_ch.cursor_row_out    = out_row_reg;
    assign out_ch.cursor_column_out = out_col_reg;
    assign out_ch.scrolled          = out_scrolled_reg;

    // Write port: a pending copy beats the fill sweep, which beats a character store.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = copy_addr_reg;
        mem_wdata = mem_rdata;
        priority if (copy_pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (fill_go)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = (state_reg == S_INIT) ? RESET_BLANK : blank_reg;
        end
        else if (char_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_base_reg + AW'(col_reg);
            mem_wdata = {attr, in_ch.char_code};
        end
    end

    assign mem_raddr = (state_reg == S_SCROLL) ? sweep_reg : AW'(in_ch.cell_index);

    always_comb
    begin
        state_next        = state_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        row_base_next     = row_base_reg;
        sweep_next        = sweep_reg;
        copy_pend_next    = 1'b0;
        copy_addr_next    = copy_addr_reg;
        blank_next        = blank_reg;
        rd_code_next      = rd_code_reg;
        rd_attr_next      = rd_attr_reg;
        scrolled_next     = scrolled_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_code_next     = out_code_reg;
        out_attr_next     = out_attr_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_scrolled_next = out_scrolled_reg;

        unique case (state_reg)
            S_INIT, S_FILL:
            begin
                if (fill_go)
                begin
                    if (sweep_reg == LAST_CELL)
                    begin
                        state_next = (state_reg == S_INIT) ? S_IDLE : S_EMIT;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_code_next  = '0;
                    rd_attr_next  = '0;
                    scrolled_next = 1'b0;
                    blank_next    = {attr, SPACE_CODE};
                    unique case (op_t'(in_ch.operation))
                        OP_WRITE:
                        begin
                            state_next = S_EMIT;
                            if (is_newline || (col_reg == LAST_COL))
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    scrolled_next = 1'b1;
                                    sweep_next    = ROW_STEP;
                                    state_next    = S_SCROLL;
                                end
                                else
                                begin
                                    row_next      = row_reg + 1'b1;
                                    row_base_next = row_base_reg + ROW_STEP;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_next      = '0;
                            col_next      = '0;
                            row_base_next = '0;
                            sweep_next    = '0;
                            state_next    = S_FILL;
                        end
                        OP_READ:
                        begin
                            state_next = read_in_range ? S_READ : S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_code_next = mem_rdata[CHAR_W-1:0];
                rd_attr_next = mem_rdata[CELL_W-1:CHAR_W];
                state_next   = S_EMIT;
            end
            S_SCROLL:
            begin
                // Read a cell one row below; the next cycle writes it one row up.
                copy_pend_next = 1'b1;
                copy_addr_next = sweep_reg - ROW_STEP;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = BOTTOM_ROW;
                    state_next = S_FILL;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (emit_free)
                begin
                    out_valid_next    = 1'b1;
                    out_code_next     = rd_code_reg;
                    out_attr_next     = rd_attr_reg;
                    out_row_next      = ROW_OUT_W'(row_reg);
                    out_col_next      = COL_OUT_W'(col_reg);
                    out_scrolled_next = scrolled_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            row_reg          <= '0;
            col_reg          <= '0;
            row_base_reg     <= '0;
            sweep_reg        <= '0;
            copy_pend_reg    <= 1'b0;
            copy_addr_reg    <= '0;
            blank_reg        <= RESET_BLANK;
            rd_code_reg      <= '0;
            rd_attr_reg      <= '0;
            scrolled_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_code_reg     <= '0;
            out_attr_reg     <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            out_scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            row_base_reg     <= row_base_next;
            sweep_reg        <= sweep_next;
            copy_pend_reg    <= copy_pend_next;
            copy_addr_reg    <= copy_addr_next;
            blank_reg        <= blank_next;
            rd_code_reg      <= rd_code_next;
            rd_attr_reg      <= rd_attr_next;
            scrolled_reg     <= scrolled_next;
            out_valid_reg    <= out_valid_next;
            out_code_reg     <= out_code_next;
            out_attr_reg     <= out_attr_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            out_scrolled_reg <= out_scrolled_next;
        end
    end
endmodule

// File: hw/rtl/text_console_cursor_scroll_top.sv
// Top level of the text console engine: color registers, screen RAM, sequencer.
//
// Character screen of ROWS x COLUMNS cells (character byte, color attribute) held in
// one RAM with a single write port and a registered read port. After reset the block
// runs a clearing pass over all ROWS*COLUMNS cells (2000 at 80x25) before it takes
// the first command; color register writes are taken at any time. A character or
// newline write passes through S_EMIT to the result register, a cell read through
// S_READ and then S_EMIT, an unused operation code through S_EMIT. A write that
// moves past the last row copies the screen up one row and blanks the bottom row in
// the current color; a clear fills every cell. One command is in flight at a time;
// a finished result waits in an output register while the next command is accepted.
module text_console_cursor_scroll_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tccs_in_if.sink                              in_ch,
    tccs_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [tccs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tccs_pkg::COLOR_W-1:0]         cfg_data
);
    import tccs_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [ATTR_W-1:0]  attr;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FOREGROUND;
            bg_reg <= RESET_BACKGROUND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOREGROUND: fg_reg <= cfg_data;
                CFG_BACKGROUND: bg_reg <= cfg_data;
                default:        fg_reg <= fg_reg;
            endcase
        end
    end

    assign attr = {bg_reg, fg_reg};

    tccs_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .mem_we    (ram_we),
        .mem_waddr (ram_waddr),
        .mem_wdata (ram_wdata),
        .mem_raddr (ram_raddr),
        .mem_rdata (ram_rdata)
    );

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < CELLS))
        else $error("screen write beyond last cell");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.ready && !in_ch.valid) |-> !ram_we)
        else $error("screen written while idle with no command");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.scrolled) |->
            (out_ch.cursor_row_out == ROW_OUT_W'(ROWS - 1)) &&
            (out_ch.cursor_column_out == '0))
        else $error("scroll result with cursor off the bottom row start");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (32'(out_ch.cursor_column_out) < COLUMNS))
        else $error("reported cursor column out of range");
`endif
endmodule

// File: test/text_console_cursor_scroll_checker.sv
// Scoreboard for the text console engine: screen and cursor model, result queue, compare.
module text_console_cursor_scroll_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tccs_in_if                               cmd_ch,
    tccs_out_if                              res_ch,
    input  logic                             cfg_we,
    input  logic [tccs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tccs_pkg::COLOR_W-1:0]     cfg_data,
    output int                               mismatch_count,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [CHAR_W-1:0]    code;
        logic [ATTR_W-1:0]    attr;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 scrolled;
    } console_result_t;

    logic [CELL_W-1:0]  screen [CELLS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    console_result_t    expected_q [$];

    function automatic logic [CELL_W-1:0] blank_cell();
        return {bg_color, fg_color, SPACE_CODE};
    endfunction

    // Move to column 0 of the next row; past the bottom, shift the screen up one row.
    function automatic logic line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = blank_cell();
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    task automatic predict_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                   input logic [INDEX_W-1:0] idx);
        console_result_t r;
        r = '0;
        case (op)
            OP_WRITE:
            begin
                if (ch == NEWLINE_CODE)
                begin
                    r.scrolled = line_feed();
                end
                else
                begin
                    screen[cur_row * COLUMNS + cur_col] = {bg_color, fg_color, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        r.scrolled = line_feed();
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = blank_cell();
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ:
            begin
                if (idx < CELLS)
                begin
                    r.code = screen[idx][CHAR_W-1:0];
                    r.attr = screen[idx][CELL_W-1:CHAR_W];
                end
            end
            default:
            begin
                // unused code: cursor reported unchanged, nothing stored
            end
        endcase
        r.row = cur_row[ROW_OUT_W-1:0];
        r.col = cur_col[COL_OUT_W-1:0];
        expected_q.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = RESET_BLANK;
            cur_row = 0;
            cur_col = 0;
            fg_color = RESET_FOREGROUND;
            bg_color = RESET_BACKGROUND;
            expected_q.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            // results first: a command accepted on this edge cannot have produced one yet
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("cell_code", 32'(want.code), 32'(res_ch.cell_code));
                    check_field("cell_attribute", 32'(want.attr),
                                32'(res_ch.cell_attribute));
                    check_field("cursor_row_out", 32'(want.row),
                                32'(res_ch.cursor_row_out));
                    check_field("cursor_column_out", 32'(want.col),
                                32'(res_ch.cursor_column_out));
                    check_field("scrolled", 32'(want.scrolled), 32'(res_ch.scrolled));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_FOREGROUND)
                    fg_color = cfg_data;
                else if (cfg_index == CFG_BACKGROUND)
                    bg_color = cfg_data;
            end
            if (cmd_ch.valid && cmd_ch.ready)
                predict_command(cmd_ch.operation, cmd_ch.char_code, cmd_ch.cell_index);
            outstanding = expected_q.size();
        end
    end

endmodule

// File: test/text_console_cursor_scroll_top_tb.sv
// Testbench top for the text console engine: clock, reset, commands, colors and verdict.
module text_console_cursor_scroll_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    localparam int ITEM_TOTAL   = 1120;
    localparam int HOLD_CYCLES  = 3000;
    localparam int IDLE_LIMIT   = 30000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]     cfg_data;
    int                     mismatches;
    int                     outstanding;
    int                     sent;
    int                     burst_left;
    int                     idle_cycles = 0;
    bit                     hold_req;

    tccs_in_if  cmd_ch ();
    tccs_out_if res_ch ();

    text_console_cursor_scroll_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_console_cursor_scroll_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) screen_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_ch         (cmd_ch),
        .res_ch         (res_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .outstanding    (outstanding)
    );

    always #10ns clk = ~clk;

    // Stop if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: switch between stall patterns; honor a long hold-off when asked.
    initial
    begin : result_sink
        int mode;
        int stretch;
        mode = 0;
        stretch = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode = $urandom_range(0, 3);
                    stretch = $urandom_range(8, 64);
                end
                stretch--;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: res_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.char_code  <= ch;
        cmd_ch.cell_index <= idx;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent++;
    endtask

    // Drop valid and wait until every result has come back.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FOREGROUND;
        cfg_data  <= fg;
        @(negedge clk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data  <= bg;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        return (c == NEWLINE_CODE) ? SPACE_CODE : c;
    endfunction

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 2047));
    endfunction

    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    initial
    begin : stimulus
        int  kind;
        int  count;
        bit  hold_early;
        bit  hold_late;
        logic [INDEX_W-1:0] idx;

        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = OP_WRITE;
        cmd_ch.char_code  = '0;
        cmd_ch.cell_index = '0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_FOREGROUND;
        cfg_data          = '0;
        burst_left        = 0;
        sent              = 0;
        hold_req          = 1'b0;
        hold_early        = 1'b0;
        hold_late         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset screen contents, out-of-range reads, unused code
        send_cmd(OP_READ, 8'h00, 11'd0);
        send_cmd(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
        send_cmd(OP_READ, 8'h00, INDEX_W'(CELLS));
        send_cmd(OP_READ, 8'hFF, 11'h7FF);
        send_cmd(OP_UNUSED, 8'h41, 11'h7FF);
        // plain, high and zero characters, then newline
        send_cmd(OP_WRITE, 8'h48, 11'd0);
        send_cmd(OP_WRITE, 8'hFF, 11'd0);
        send_cmd(OP_WRITE, 8'h00, 11'd0);
        send_cmd(OP_WRITE, NEWLINE_CODE, 11'd0);
        send_cmd(OP_READ, 8'h00, 11'd0);
        send_cmd(OP_READ, 8'h00, 11'd1);
        send_cmd(OP_READ, 8'h00, 11'd2);
        set_colors(4'hF, 4'hF);
        send_cmd(OP_WRITE, 8'h80, 11'd0);
        send_cmd(OP_READ, 8'h00, INDEX_W'(COLUMNS));
        // new color must not touch cells already stored
        set_colors(4'h0, 4'h0);
        send_cmd(OP_WRITE, 8'h7F, 11'd0);
        send_cmd(OP_READ, 8'h00, INDEX_W'(COLUMNS + 1));
        send_cmd(OP_READ, 8'h00, INDEX_W'(COLUMNS));
        set_colors(4'hA, 4'h5);
        send_cmd(OP_CLEAR, 8'h00, 11'd0);
        send_cmd(OP_READ, 8'h00, 11'd0);
        send_cmd(OP_READ, 8'h00, INDEX_W'(CELLS - 1));

        while (sent < ITEM_TOTAL)
        begin
            // keep feeding commands while the result side holds off
            if (!hold_early && sent >= 400)
            begin
                hold_req = 1'b1;
                hold_early = 1'b1;
            end
            if (!hold_late && sent >= 850)
            begin
                hold_req = 1'b1;
                hold_late = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                count = $urandom_range(0, 30);
                repeat (count) send_cmd(OP_WRITE, text_char(), any_index());
                send_cmd(OP_WRITE, NEWLINE_CODE, any_index());
            end
            else if (kind < 55)
            begin
                // long line that wraps past the last column
                count = $urandom_range(60, 170);
                repeat (count) send_cmd(OP_WRITE, text_char(), any_index());
            end
            else if (kind < 80)
            begin
                count = $urandom_range(1, 8);
                repeat (count)
                begin
                    case ($urandom_range(0, 9))
                        0: idx = any_index();
                        1, 2, 3, 4: idx = INDEX_W'($urandom_range(CELLS - 3 * COLUMNS,
                                                                  CELLS - 1));
                        default: idx = INDEX_W'($urandom_range(0, CELLS - 1));
                    endcase
                    send_cmd(OP_READ, any_char(), idx);
                end
            end
            else if (kind < 88)
            begin
                count = $urandom_range(1, 6);
                repeat (count)
                    send_cmd(OP_W'($urandom_range(0, 3)), any_char(), any_index());
            end
            else if (kind < 92)
            begin
                send_cmd(OP_CLEAR, any_char(), any_index());
            end
            else if (kind < 96)
            begin
                set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
            end
            else
            begin
                // run of newlines: scroll repeatedly at the bottom row
                count = $urandom_range(1, 30);
                repeat (count) send_cmd(OP_WRITE, NEWLINE_CODE, any_index());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_if.sv
hw/rtl/tccs_ram.sv
hw/rtl/tccs_ctrl.sv
hw/rtl/text_console_cursor_scroll_top.sv
test/text_console_cursor_scroll_checker.sv
test/text_console_cursor_scroll_top_tb.sv
